/* rtl/nearest_palette_color_mapper_top_defines.svh */
// Assertion macros for the nearest palette color mapper.
// Used by nearest_palette_color_mapper_top; expects clk and rst_n in scope.
`ifndef NEAREST_PALETTE_COLOR_MAPPER_TOP_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_MAPPER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define NPCM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("npcm assertion failed (same cycle)");

// next-cycle implication, disabled during reset
`define NPCM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("npcm assertion failed (next cycle)");

`endif

/* rtl/npcm_pkg.sv */
// Shared types and constants for the nearest palette color mapper.
// No dependencies.
package npcm_pkg;

    localparam int unsigned MAX_COLORS_DEF = 16;
    localparam int unsigned MAX_COLORS_LIM = 256;
    localparam int unsigned BEST_W         = $clog2(MAX_COLORS_LIM);
    localparam int unsigned DIST_W         = 18;
    localparam int unsigned SIZE_W         = 5;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_MAP  = 1'b1;

    typedef struct packed {
        logic       action;
        logic [3:0] slot_index;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } in_word_t;

    typedef struct packed {
        logic [3:0] best_index;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } out_word_t;

    // word passed from one cell to the next
    typedef struct packed {
        logic              valid;
        in_word_t          item;
        logic [DIST_W-1:0] best_dist;
        logic [BEST_W-1:0] best_idx;
        logic [23:0]       best_color;
    } cell_bus_t;

endpackage

/* rtl/npcm_cell.sv */
// One palette slot of the search chain: holds its color, updates the running best.
// Depends on npcm_pkg.
module npcm_cell #(
    parameter int unsigned INDEX = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic [npcm_pkg::SIZE_W-1:0] palette_size,
    input  npcm_pkg::cell_bus_t        bus_in,
    output npcm_pkg::cell_bus_t        bus_out
);

    logic [23:0]                   entry_reg;
    logic                          valid_reg;
    npcm_pkg::cell_bus_t           data_reg;
    npcm_pkg::cell_bus_t           data_next;
    logic [7:0]                    dr, dg, db;
    logic [15:0]                   sr, sg, sb;
    logic [npcm_pkg::DIST_W-1:0]   sq_dist;
    logic                          active;
    logic                          take;
    logic                          write_en;

    always_comb
    begin
        dr = (bus_in.item.red_in > entry_reg[23:16]) ?
             bus_in.item.red_in - entry_reg[23:16] : entry_reg[23:16] - bus_in.item.red_in;
        dg = (bus_in.item.green_in > entry_reg[15:8]) ?
             bus_in.item.green_in - entry_reg[15:8] : entry_reg[15:8] - bus_in.item.green_in;
        db = (bus_in.item.blue_in > entry_reg[7:0]) ?
             bus_in.item.blue_in - entry_reg[7:0] : entry_reg[7:0] - bus_in.item.blue_in;
        sr = dr * dr;
        sg = dg * dg;
        sb = db * db;
        sq_dist = npcm_pkg::DIST_W'(sr) + npcm_pkg::DIST_W'(sg) + npcm_pkg::DIST_W'(sb);

        // size 0 searches slot 0 only
        active = (INDEX == 0) || (INDEX < 32'(palette_size));
        take   = bus_in.valid && (bus_in.item.action == npcm_pkg::ACT_MAP) && active &&
                 ((INDEX == 0) || (sq_dist < bus_in.best_dist));
        write_en = advance && bus_in.valid && (bus_in.item.action == npcm_pkg::ACT_LOAD) &&
                   (32'(bus_in.item.slot_index) == INDEX);

        data_next = bus_in;
        if (take)
        begin
            data_next.best_dist  = sq_dist;
            data_next.best_idx   = npcm_pkg::BEST_W'(INDEX);
            data_next.best_color = entry_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= bus_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
        if (write_en)
        begin
            entry_reg <= {bus_in.item.red_in, bus_in.item.green_in, bus_in.item.blue_in};
        end
    end

    always_comb
    begin
        bus_out       = data_reg;
        bus_out.valid = valid_reg;
    end

endmodule

/* rtl/nearest_palette_color_mapper_top.sv */
// Top level of the nearest palette color mapper: chain of npcm_cell plus output register.
// Depends on npcm_pkg, npcm_cell and nearest_palette_color_mapper_top_defines.svh.
//
//  channel | signals                      | word
//  --------+------------------------------+---------------------------
//  in      | in_valid, in_stall, in_word  | load or map item
//  out     | out_valid, out_stall, out_word| nearest slot and its color
//  cfg     | cfg_valid, cfg_ready, cfg_data| palette_size
//
// Every word (load or map) walks the chain of MAX_COLORS cells, one cell per cycle while
// the output is not stalled, then the output register, where a map raises out_valid.
// One word is accepted per cycle unless in_stall is high; loads give no result.
// A stalled result freezes the whole chain, so in_stall follows out_valid && out_stall.
// Reset clears valid bits and sets palette_size to 16; palette colors are unset.
`include "nearest_palette_color_mapper_top_defines.svh"

module nearest_palette_color_mapper_top #(
    parameter int unsigned MAX_COLORS = npcm_pkg::MAX_COLORS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  npcm_pkg::in_word_t          in_word,
    output logic                        out_valid,
    input  logic                        out_stall,
    output npcm_pkg::out_word_t         out_word,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [npcm_pkg::SIZE_W-1:0] cfg_data
);

    logic [npcm_pkg::SIZE_W-1:0] size_reg;
    logic                        out_valid_reg;
    npcm_pkg::out_word_t         out_word_reg;
    logic                        advance;
    npcm_pkg::cell_bus_t         bus [MAX_COLORS+1];
    npcm_pkg::cell_bus_t         tail;
    logic                        tail_map;
    logic                        tail_load;
    logic                        idx_ok;

    assign advance   = !(out_valid_reg && out_stall);
    assign in_stall  = !advance;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        bus[0]            = '0;
        bus[0].valid      = in_valid;
        bus[0].item       = in_word;
        bus[0].best_dist  = '1;
    end

    for (genvar k = 0; k < MAX_COLORS; k++)
    begin : g_cell
        npcm_cell #(
            .INDEX (k)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .advance      (advance),
            .palette_size (size_reg),
            .bus_in       (bus[k]),
            .bus_out      (bus[k+1])
        );
    end

    assign tail      = bus[MAX_COLORS];
    assign tail_map  = tail.valid && (tail.item.action == npcm_pkg::ACT_MAP);
    assign tail_load = tail.valid && (tail.item.action == npcm_pkg::ACT_LOAD);
    assign idx_ok    = (out_word_reg.best_index == 4'd0) ||
                       (5'(out_word_reg.best_index) < size_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= npcm_pkg::SIZE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                size_reg <= cfg_data;
            end
            if (advance)
            begin
                out_valid_reg <= tail_map;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_word_reg.best_index <= tail.best_idx[3:0];
            out_word_reg.red_out    <= tail.best_color[23:16];
            out_word_reg.green_out  <= tail.best_color[15:8];
            out_word_reg.blue_out   <= tail.best_color[7:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // a load reaching the end of the chain never makes a result
    `NPCM_ASSERT_NEXT(a_load_no_result, tail_load && advance, !out_valid_reg)
    // the chosen slot lies inside the searched range
    `NPCM_ASSERT_NOW(a_index_in_range, out_valid_reg, idx_ok)
    // a map word at the tail yields a result next cycle
    `NPCM_ASSERT_NEXT(a_map_gives_result, tail_map && advance, out_valid_reg)

endmodule
